@@ rtl/core/near_far_lz_word_expand_assert.svh @@
// Assertion macros for the near/far LZ word expander.
// Define ASSERT_OFF to compile the checks out.
`ifndef NEAR_FAR_LZ_WORD_EXPAND_ASSERT_SVH
`define NEAR_FAR_LZ_WORD_EXPAND_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define NFLZ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NFLZ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define NFLZ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)

`define NFLZ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/core/nflz_pkg.sv @@
package nflz_pkg;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int CNT_W      = 14;
  localparam int COUNT_W    = 3;
  localparam int PER_RESULT = 4;
  localparam int LANE_W     = 2;

  localparam logic [BYTE_W-1:0] NEAR_TAG = 8'hA7;
  localparam logic [BYTE_W-1:0] FAR_TAG  = 8'hA8;

  localparam logic [CNT_W-1:0] OUTPUT_WORDS_RESET = 14'd4097;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              block_start;
  } nflz_in_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word_a;
    logic [WORD_W-1:0]  word_b;
    logic [WORD_W-1:0]  word_c;
    logic [WORD_W-1:0]  word_d;
    logic [COUNT_W-1:0] word_count;
    logic               item_last;
    logic               block_end;
    logic               bad_reference;
    logic               overrun;
  } nflz_out_t;

  typedef struct packed {
    logic [CNT_W-1:0] output_words;
  } nflz_cfg_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LIT,
    CMD_NEAR,
    CMD_FAR
  } nflz_kind_t;

  // Decoded token handed from the parser to the history engine.
  typedef struct packed {
    nflz_kind_t        kind;
    logic [WORD_W-1:0] word;
    logic [BYTE_W-1:0] count;
    logic [WORD_W-1:0] offset;
  } nflz_cmd_t;

endpackage

@@ rtl/core/nflz_chan_if.sv @@
interface nflz_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ rtl/core/nflz_parse.sv @@
module nflz_parse (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic                      restart,
  input  logic [nflz_pkg::BYTE_W-1:0] data_byte,
  output nflz_pkg::nflz_cmd_t       cmd
);
  import nflz_pkg::*;

  typedef enum logic [2:0] {
    PH_LOW,
    PH_HIGH,
    PH_NEAR_DIST,
    PH_FAR_LOW,
    PH_FAR_HIGH,
    PH_ESCAPE
  } phase_t;

  phase_t            phase;
  phase_t            phase_cur;
  phase_t            phase_next;
  logic [BYTE_W-1:0] token_low;
  logic [BYTE_W-1:0] token_high;
  logic [BYTE_W-1:0] far_low;
  logic              is_tag;

  // A block start drops any half-parsed token before this byte.
  assign phase_cur = restart ? PH_LOW : phase;
  assign is_tag    = (data_byte == NEAR_TAG) || (data_byte == FAR_TAG);

  always_comb begin
    cmd        = '0;
    cmd.kind   = CMD_NONE;
    phase_next = phase_cur;
    unique case (phase_cur)
      PH_LOW: begin
        phase_next = PH_HIGH;
      end
      PH_HIGH: begin
        if (is_tag) begin
          if (token_low == '0) begin
            phase_next = PH_ESCAPE;
          end else if (data_byte == NEAR_TAG) begin
            phase_next = PH_NEAR_DIST;
          end else begin
            phase_next = PH_FAR_LOW;
          end
        end else begin
          cmd.kind   = CMD_LIT;
          cmd.word   = {data_byte, token_low};
          phase_next = PH_LOW;
        end
      end
      PH_NEAR_DIST: begin
        cmd.kind   = CMD_NEAR;
        cmd.count  = token_low;
        cmd.offset = {{(WORD_W-BYTE_W){1'b0}}, data_byte};
        phase_next = PH_LOW;
      end
      PH_FAR_LOW: begin
        phase_next = PH_FAR_HIGH;
      end
      PH_FAR_HIGH: begin
        cmd.kind   = CMD_FAR;
        cmd.count  = token_low;
        cmd.offset = {data_byte, far_low};
        phase_next = PH_LOW;
      end
      PH_ESCAPE: begin
        cmd.kind   = CMD_LIT;
        cmd.word   = {token_high, data_byte};
        phase_next = PH_LOW;
      end
      default: begin
        phase_next = PH_LOW;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LOW;
    end else if (step) begin
      phase <= phase_next;
    end else if (restart) begin
      phase <= PH_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (phase_cur == PH_LOW) token_low <= data_byte;
      if (phase_cur == PH_HIGH) token_high <= data_byte;
      if (phase_cur == PH_FAR_LOW) far_low <= data_byte;
    end
  end

endmodule

@@ rtl/core/nflz_engine.sv @@
module nflz_engine #(
  parameter int HISTORY_WORDS = 8192
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic                       block_start,
  input  nflz_pkg::nflz_cmd_t        cmd,
  input  logic [nflz_pkg::CNT_W-1:0] output_words,
  output logic                       ready,
  output logic                       active,
  output nflz_pkg::nflz_out_t        res,
  output logic                       res_valid,
  input  logic                       res_ready
);
  import nflz_pkg::*;

  localparam int AW      = $clog2(HISTORY_WORDS);
  localparam int CntMax  = (1 << CNT_W) - 1;
  localparam int HistCap = (HISTORY_WORDS > CntMax) ? CntMax : HISTORY_WORDS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_WR
  } state_t;

  logic [WORD_W-1:0] mem [HISTORY_WORDS];
  logic [WORD_W-1:0] rd_data;

  state_t            state;
  logic [CNT_W-1:0]  ww;
  logic              done;
  logic [CNT_W-1:0]  src;
  logic [CNT_W-1:0]  dst;
  logic [BYTE_W-1:0] left;
  logic [LANE_W-1:0] lane;
  logic              bad;
  logic              over;
  logic              ends;
  logic [WORD_W-1:0] coll [PER_RESULT-1];

  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  ww_eff;
  logic              done_eff;
  logic              can_push;
  logic              take;
  logic              is_copy;
  logic [CNT_W-1:0]  rem;
  logic              over_now;
  logic [BYTE_W-1:0] cnt;
  logic [BYTE_W-1:0] near_dist;
  logic              bad_now;
  logic [CNT_W-1:0]  src_now;
  logic              lit_end;
  logic              copy_end;
  logic [WORD_W-1:0] cp_word;
  logic              flush;
  logic              last_word;
  logic              advance;
  logic [WORD_W-1:0] pk [PER_RESULT];
  logic              we;
  logic [CNT_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic              res_load;
  nflz_out_t         lit_res;
  nflz_out_t         cp_res;

  assign limit    = (output_words > CNT_W'(HistCap)) ? CNT_W'(HistCap) : output_words;
  assign ww_eff   = block_start ? '0 : ww;
  assign done_eff = block_start ? 1'b0 : done;
  assign active   = !done_eff && (ww_eff < limit);
  assign can_push = !res_valid || res_ready;
  assign ready    = (state == S_IDLE) && can_push;
  assign take     = accept && active;
  assign is_copy  = (cmd.kind == CMD_NEAR) || (cmd.kind == CMD_FAR);

  // Clip the copy to what is left of the block.
  assign rem       = limit - ww_eff;
  assign over_now  = CNT_W'(cmd.count) > rem;
  assign cnt       = over_now ? rem[BYTE_W-1:0] : cmd.count;
  assign near_dist = cmd.offset[BYTE_W-1:0];

  always_comb begin
    if (cmd.kind == CMD_FAR) begin
      bad_now = cmd.offset >= WORD_W'(ww_eff);
      src_now = cmd.offset[CNT_W-1:0];
    end else begin
      bad_now = (near_dist == '0) || (CNT_W'(near_dist) > ww_eff);
      src_now = ww_eff - CNT_W'(near_dist);
    end
  end

  assign lit_end  = (ww_eff + CNT_W'(1)) >= limit;
  assign copy_end = (ww_eff + CNT_W'(cnt)) >= limit;

  assign cp_word   = bad ? '0 : rd_data;
  assign last_word = (left == BYTE_W'(1));
  assign flush     = (lane == LANE_W'(PER_RESULT - 1)) || last_word;
  assign advance   = (state == S_WR) && (!flush || can_push);

  // Unused lanes of the collector stay zero, so they pack straight through.
  always_comb begin
    for (int j = 0; j < PER_RESULT - 1; j++) begin
      pk[j] = (lane == LANE_W'(j)) ? cp_word : coll[j];
    end
    pk[PER_RESULT-1] = (lane == LANE_W'(PER_RESULT - 1)) ? cp_word : '0;
  end

  always_comb begin
    lit_res            = '0;
    lit_res.word_a     = cmd.word;
    lit_res.word_count = COUNT_W'(1);
    lit_res.item_last  = 1'b1;
    lit_res.block_end  = lit_end;
  end

  always_comb begin
    cp_res               = '0;
    cp_res.word_a        = pk[0];
    cp_res.word_b        = pk[1];
    cp_res.word_c        = pk[2];
    cp_res.word_d        = pk[3];
    cp_res.word_count    = COUNT_W'(lane) + COUNT_W'(1);
    cp_res.item_last     = last_word;
    cp_res.block_end     = last_word && ends;
    cp_res.bad_reference = bad;
    cp_res.overrun       = over;
  end

  assign res_load = (take && (cmd.kind == CMD_LIT)) || (advance && flush);

  assign we    = (take && (cmd.kind == CMD_LIT)) || advance;
  assign waddr = (state == S_WR) ? dst : ww_eff;
  assign wdata = (state == S_WR) ? cp_word : cmd.word;

  // Each copied word is written before the next source read is issued,
  // so an overlapping near copy always sees its own fresh output.
  always_ff @(posedge clk) begin
    if (we) mem[AW'(waddr)] <= wdata;
    if (state == S_RD) rd_data <= mem[AW'(src)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ww        <= '0;
      done      <= 1'b0;
      res_valid <= 1'b0;
      lane      <= '0;
    end else begin
      res_valid <= res_load || (res_valid && !res_ready);
      unique case (state)
        S_IDLE: begin
          if (take && (cmd.kind == CMD_LIT)) begin
            ww   <= ww_eff + CNT_W'(1);
            done <= lit_end;
            res  <= lit_res;
          end else if (take && is_copy) begin
            ww    <= ww_eff + CNT_W'(cnt);
            done  <= copy_end;
            state <= S_RD;
            lane  <= '0;
            src   <= src_now;
            dst   <= ww_eff;
            left  <= cnt;
            bad   <= bad_now;
            over  <= over_now;
            ends  <= copy_end;
            for (int j = 0; j < PER_RESULT - 1; j++) coll[j] <= '0;
          end else if (accept) begin
            ww   <= ww_eff;
            done <= done_eff;
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (advance) begin
            src   <= src + CNT_W'(1);
            dst   <= dst + CNT_W'(1);
            left  <= left - BYTE_W'(1);
            state <= last_word ? S_IDLE : S_RD;
            if (flush) begin
              res  <= cp_res;
              lane <= '0;
              for (int j = 0; j < PER_RESULT - 1; j++) coll[j] <= '0;
            end else begin
              coll[lane] <= cp_word;
              lane       <= lane + LANE_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/near_far_lz_word_expand.sv @@
// Channel   Dir   Payload                                      Beat when
// cfg       in    output_words                                 cfg.valid & cfg.ready
// stream    in    data_byte, block_start                       stream.valid & stream.ready
// words     out   word_a..word_d, word_count, flags            words.valid & words.ready
//
// Token bytes that finish no word and literal bytes are taken back to back.
// A copy byte of n words holds stream.ready low while each word is read from
// the history RAM, which has one registered read port, and then written back.
// Reset clears parser, counters and result valid and reloads output_words; history
// holds no reset value; a copy source at or past the write pointer reads as zero.
// A full result register that is not taken holds stream.ready low.
`include "near_far_lz_word_expand_assert.svh"

module near_far_lz_word_expand #(
  parameter int HISTORY_WORDS = 8192
) (
  input  logic         clk,
  input  logic         rst,
  nflz_chan_if.sink    cfg,
  nflz_chan_if.sink    stream,
  nflz_chan_if.source  words
);
  import nflz_pkg::*;

  logic [CNT_W-1:0] output_words;
  logic             accept;
  logic             active;
  logic             eng_ready;
  logic             res_valid;
  nflz_out_t        res;
  nflz_cmd_t        cmd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_words <= OUTPUT_WORDS_RESET;
    end else if (cfg.valid) begin
      output_words <= cfg.data.output_words;
    end
  end

  assign stream.ready = eng_ready;
  assign accept       = stream.valid && stream.ready;

  nflz_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (accept && active),
    .restart   (accept && stream.data.block_start),
    .data_byte (stream.data.data_byte),
    .cmd       (cmd)
  );

  nflz_engine #(
    .HISTORY_WORDS (HISTORY_WORDS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .block_start  (stream.data.block_start),
    .cmd          (cmd),
    .output_words (output_words),
    .ready        (eng_ready),
    .active       (active),
    .res          (res),
    .res_valid    (res_valid),
    .res_ready    (words.ready)
  );

  assign words.valid = res_valid;
  assign words.data  = res;

  `NFLZ_ASSERT_IMP(a_pack_full, clk, rst, words.valid && !words.data.item_last, words.data.word_count == COUNT_W'(PER_RESULT), "partial result before end of copy")
  `NFLZ_ASSERT_IMP(a_end_last, clk, rst, words.valid && words.data.block_end, words.data.item_last, "block end on a non-final result")
  `NFLZ_ASSERT_IMP(a_tail_zero, clk, rst, words.valid && (words.data.word_count != COUNT_W'(PER_RESULT)), words.data.word_d == '0, "unused word lane not zero")
  `NFLZ_ASSERT_NEXT(a_hold_beat, clk, rst, words.valid && !words.ready, words.valid && $stable(words.data), "result beat dropped or changed while stalled")

endmodule

@@ dv/near_far_lz_word_expand_tb.sv @@
module near_far_lz_word_expand_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nflz_pkg::*;

  localparam int HIST_DEPTH = 8192;
  localparam int RAND_BYTES = 250;

  typedef enum int {
    P_LOW,
    P_HIGH,
    P_NEAR_DIST,
    P_FAR_LOW,
    P_FAR_HIGH,
    P_ESCAPE
  } parse_e;

  class expand_scoreboard;
    logic [WORD_W-1:0] hist [HIST_DEPTH];
    int                length_words = OUTPUT_WORDS_RESET;
    parse_e            phase = P_LOW;
    logic [BYTE_W-1:0] tok_low = '0;
    logic [BYTE_W-1:0] tok_high = '0;
    logic [BYTE_W-1:0] far_low = '0;
    int                written = 0;
    bit                done = 1'b0;
    nflz_out_t         pending [$];
    int                errors = 0;

    function int limit();
      return (length_words > HIST_DEPTH) ? HIST_DEPTH : length_words;
    endfunction

    function bit halted();
      return done || (written >= limit());
    endfunction

    function void set_length(logic [CNT_W-1:0] n);
      length_words = int'(n);
    endfunction

    // Split a run of decoded words into beats of up to four.
    function void queue_words(logic [WORD_W-1:0] run [$], bit bad, bit over);
      int        nres;
      int        cnt;
      bit        ends;
      nflz_out_t r;
      nres = (run.size() + PER_RESULT - 1) / PER_RESULT;
      ends = written >= limit();
      for (int k = 0; k < nres; k++) begin
        cnt = run.size() - k * PER_RESULT;
        if (cnt > PER_RESULT) cnt = PER_RESULT;
        r = '0;
        r.word_a = run[k*PER_RESULT];
        if (cnt > 1) r.word_b = run[k*PER_RESULT+1];
        if (cnt > 2) r.word_c = run[k*PER_RESULT+2];
        if (cnt > 3) r.word_d = run[k*PER_RESULT+3];
        r.word_count    = COUNT_W'(cnt);
        r.item_last     = (k == nres - 1);
        r.block_end     = (k == nres - 1) && ends;
        r.bad_reference = bad;
        r.overrun       = over;
        pending.push_back(r);
      end
      if (ends) done = 1'b1;
    endfunction

    function void literal_word(logic [WORD_W-1:0] w);
      logic [WORD_W-1:0] run [$];
      if (written < HIST_DEPTH) hist[written] = w;
      written++;
      phase = P_LOW;
      run.push_back(w);
      queue_words(run, 1'b0, 1'b0);
    endfunction

    function void copy_words(bit is_far, int offset);
      int                pos;
      int                count;
      int                src;
      bit                over;
      bit                bad;
      logic [WORD_W-1:0] w;
      logic [WORD_W-1:0] run [$];
      pos   = written;
      count = int'(tok_low);
      over  = count > (limit() - pos);
      if (over) count = limit() - pos;
      if (is_far) begin
        bad = offset >= pos;
        src = offset;
      end else begin
        bad = (offset == 0) || (offset > pos);
        src = bad ? 0 : pos - offset;
      end
      // Copy word by word so overlapping near copies repeat the pattern.
      for (int i = 0; i < count; i++) begin
        w = '0;
        if (!bad && (src + i) < HIST_DEPTH) w = hist[src+i];
        if ((pos + i) < HIST_DEPTH) hist[pos+i] = w;
        run.push_back(w);
      end
      written = pos + count;
      phase = P_LOW;
      queue_words(run, bad, over);
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b, logic start);
      if (start) begin
        phase    = P_LOW;
        tok_low  = '0;
        tok_high = '0;
        far_low  = '0;
        written  = 0;
        done     = 1'b0;
      end
      if (halted()) return;
      case (phase)
        P_HIGH: begin
          tok_high = b;
          if (b == NEAR_TAG || b == FAR_TAG) begin
            if (tok_low == '0) phase = P_ESCAPE;
            else phase = (b == NEAR_TAG) ? P_NEAR_DIST : P_FAR_LOW;
          end else begin
            literal_word({tok_high, tok_low});
          end
        end
        P_NEAR_DIST: copy_words(1'b0, int'(b));
        P_FAR_LOW: begin
          far_low = b;
          phase = P_FAR_HIGH;
        end
        P_FAR_HIGH: copy_words(1'b1, int'({b, far_low}));
        P_ESCAPE: literal_word({tok_high, b});
        default: begin
          tok_low = b;
          phase = P_HIGH;
        end
      endcase
    endfunction

    function void cmp_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_beat(nflz_out_t got);
      nflz_out_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: output beat expected none actual %p", $time, got);
        return;
      end
      want = pending.pop_front();
      cmp_field("word_a", want.word_a, got.word_a);
      cmp_field("word_b", want.word_b, got.word_b);
      cmp_field("word_c", want.word_c, got.word_c);
      cmp_field("word_d", want.word_d, got.word_d);
      cmp_field("word_count", WORD_W'(want.word_count), WORD_W'(got.word_count));
      cmp_field("item_last", WORD_W'(want.item_last), WORD_W'(got.item_last));
      cmp_field("block_end", WORD_W'(want.block_end), WORD_W'(got.block_end));
      cmp_field("bad_reference", WORD_W'(want.bad_reference), WORD_W'(got.bad_reference));
      cmp_field("overrun", WORD_W'(want.overrun), WORD_W'(got.overrun));
    endfunction
  endclass

  logic clk;
  logic rst;

  nflz_chan_if #(.payload_t(nflz_cfg_t)) cfg_ch ();
  nflz_chan_if #(.payload_t(nflz_in_t))  stream_ch ();
  nflz_chan_if #(.payload_t(nflz_out_t)) words_ch ();

  near_far_lz_word_expand u_top (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .stream (stream_ch),
    .words  (words_ch)
  );

  expand_scoreboard sb = new;
  bit quiet    = 1'b0;
  bit hold_req = 1'b0;
  int fed      = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("near_far_lz_word_expand_tb: done, errors");
    $finish;
  end

  // Output side: check each beat, then pick ready for the next cycle.
  initial begin
    int hold_left;
    hold_left = 0;
    words_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && words_ch.valid && words_ch.ready) sb.check_beat(words_ch.data);
      if (hold_req && hold_left == 0) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        words_ch.ready <= 1'b0;
      end else begin
        words_ch.ready <= quiet || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  task automatic push(logic [BYTE_W-1:0] b, logic start);
    nflz_in_t pkt;
    pkt.data_byte   = b;
    pkt.block_start = start;
    while (!quiet && $urandom_range(0, 99) < 33) begin
      stream_ch.valid <= 1'b0;
      @(posedge clk);
    end
    if (start || !sb.halted()) fed++;
    stream_ch.valid <= 1'b1;
    stream_ch.data  <= pkt;
    do @(posedge clk); while (!stream_ch.ready);
    sb.take_byte(b, start);
  endtask

  // Hold the input until every expected beat is out, then let the parser settle.
  task automatic drain();
    stream_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_length(logic [CNT_W-1:0] n);
    nflz_cfg_t c;
    c.output_words = n;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_length(n);
  endtask

  task automatic send_token(logic start);
    int                w;
    int                kind;
    int                cnt;
    logic [WORD_W-1:0] offset;
    logic [BYTE_W-1:0] hi;
    w    = start ? 0 : sb.written;
    kind = $urandom_range(0, 99);
    cnt  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8);
    if (kind < 40) begin
      hi = BYTE_W'($urandom_range(0, 255));
      if (hi == NEAR_TAG || hi == FAR_TAG) hi = ~hi;
      push(BYTE_W'($urandom_range(0, 255)), start);
      push(hi, 1'b0);
    end else if (kind < 50) begin
      push(8'h00, start);
      push($urandom_range(0, 1) ? NEAR_TAG : FAR_TAG, 1'b0);
      push(BYTE_W'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 75) begin
      push(BYTE_W'(cnt), start);
      push(NEAR_TAG, 1'b0);
      if (w > 0 && $urandom_range(0, 99) < 85)
        push(BYTE_W'($urandom_range(1, (w > 255) ? 255 : w)), 1'b0);
      else
        push(BYTE_W'($urandom_range(0, 255)), 1'b0);
    end else if (kind < 92) begin
      if (w > 0 && $urandom_range(0, 99) < 85) offset = WORD_W'($urandom_range(0, w - 1));
      else offset = WORD_W'($urandom_range(0, 65535));
      push(BYTE_W'(cnt), start);
      push(FAR_TAG, 1'b0);
      push(offset[7:0], 1'b0);
      push(offset[15:8], 1'b0);
    end else begin
      // Stray byte: misaligns the token stream, sometimes restarts the block.
      push(BYTE_W'($urandom_range(0, 255)), start || ($urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    int  len;
    int  nblocks;
    bit  restart;
    bit  near_sent;
    rst <= 1'b1;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    stream_ch.valid <= 1'b0;
    stream_ch.data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: first tokens run under the reset length.
    push(8'h00, 1'b1); push(8'hff, 1'b0);                    // literal
    push(8'h00, 1'b0); push(NEAR_TAG, 1'b0); push(8'h5a, 1'b0); // escaped near tag
    push(8'h00, 1'b0); push(FAR_TAG, 1'b0); push(8'hff, 1'b0);  // escaped far tag
    push(8'h03, 1'b0); push(NEAR_TAG, 1'b0); push(8'h01, 1'b0); // overlapping near copy
    push(8'h06, 1'b0); push(FAR_TAG, 1'b0);
    push(8'h00, 1'b0); push(8'h00, 1'b0);                    // far copy from start
    push(8'h02, 1'b0); push(NEAR_TAG, 1'b0); push(8'h00, 1'b0); // near distance zero
    push(8'h01, 1'b0); push(FAR_TAG, 1'b0);
    push(8'hff, 1'b0); push(8'hff, 1'b0);                    // far position ahead
    drain();
    write_length(14'd20);
    push(8'hff, 1'b0); push(NEAR_TAG, 1'b0); push(8'hff, 1'b0); // bad and clipped
    drain();
    write_length(14'd1);
    push(8'h5a, 1'b1); push(8'h3c, 1'b0);
    push(8'h77, 1'b0);                                       // ignored after block end

    // Random: back up the output early so the input stalls.
    fed = 0;
    hold_req = 1'b1;
    while (fed < RAND_BYTES) begin
      case ($urandom_range(0, 9))
        0: len = 1;
        1: len = 2;
        2, 3: len = $urandom_range(65, 400);
        default: len = $urandom_range(3, 64);
      endcase
      drain();
      write_length(CNT_W'(len));
      // Sometimes continue the old block under the new length.
      restart = $urandom_range(0, 4) != 0;
      nblocks = $urandom_range(1, 3);
      for (int b = 0; b < nblocks; b++) begin
        for (int t = 0; t < 80; t++) begin
          if (!(t == 0 && (restart || b > 0)) && sb.halted()) break;
          send_token(t == 0 && (restart || b > 0));
        end
        repeat ($urandom_range(0, 2)) push(BYTE_W'($urandom_range(0, 255)), 1'b0);
      end
    end

    // Fill the whole history with long copies, no idling on either side.
    drain();
    quiet = 1'b1;
    write_length(14'd8192);
    near_sent = 1'b0;
    push(8'h11, 1'b1);
    push(8'h22, 1'b0);
    while (!sb.halted()) begin
      if (!near_sent && sb.written >= 255) begin
        near_sent = 1'b1;
        push(8'hff, 1'b0); push(NEAR_TAG, 1'b0); push(8'hff, 1'b0);
      end else begin
        push(8'hff, 1'b0); push(FAR_TAG, 1'b0); push(8'h00, 1'b0); push(8'h00, 1'b0);
      end
    end
    drain();
    quiet = 1'b0;
    write_length(14'd4097);
    for (int t = 0; t < 30; t++) send_token(t == 0);

    stream_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("near_far_lz_word_expand_tb: done, clean");
    else
      $display("near_far_lz_word_expand_tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/nflz_pkg.sv
rtl/core/nflz_chan_if.sv
rtl/core/nflz_parse.sv
rtl/core/nflz_engine.sv
rtl/core/near_far_lz_word_expand.sv
dv/near_far_lz_word_expand_tb.sv
